/* src/sslsu_pkg.sv */
package sslsu_pkg;

    // Field widths of the request and result transfers.
    localparam int SECTOR_W = 48;
    localparam int TAG_W    = 8;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_DISPATCH = 2'd1,
        REQ_REMOVE   = 2'd2,
        REQ_QUERY    = 2'd3
    } req_type_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Compare modes of the shared compare unit.
    typedef enum logic [1:0] {
        CMP_NOT_BELOW,
        CMP_ABOVE,
        CMP_BELOW,
        CMP_TAG_EQ
    } cmp_mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEIGH,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } state_t;

    typedef logic [SECTOR_W-1:0] sect_addr_t;
    typedef logic [TAG_W-1:0]    tag_t;

    // One queue entry as stored in the entry memory.
    typedef struct packed {
        tag_t       tag;
        sect_addr_t sector;
    } entry_t;

    // Request transfer payload.
    typedef struct packed {
        req_type_t  req_type;
        tag_t       req_tag;
        sect_addr_t req_sector;
    } req_t;

    // Result transfer payload.
    typedef struct packed {
        status_t    status;
        tag_t       served_tag;
        sect_addr_t served_sector;
        logic       former_valid;
        tag_t       former_tag;
        logic       latter_valid;
        tag_t       latter_tag;
    } rsp_t;

endpackage

/* src/sslsu_mem.sv */
module sslsu_mem
    import sslsu_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/sslsu_cmp.sv */
module sslsu_cmp
    import sslsu_pkg::*;
(
    input  cmp_mode_t  mode,
    input  entry_t     entry,
    input  sect_addr_t key_sector,
    input  tag_t       key_tag,
    output logic       hit
);

    logic sec_lt;
    logic sec_eq;

    // A single magnitude comparator serves every sector test.
    assign sec_lt = entry.sector < key_sector;
    assign sec_eq = entry.sector == key_sector;

    always_comb begin
        case (mode)
            CMP_NOT_BELOW: hit = !sec_lt;
            CMP_ABOVE:     hit = !sec_lt && !sec_eq;
            CMP_BELOW:     hit = sec_lt;
            CMP_TAG_EQ:    hit = entry.tag == key_tag;
            default:       hit = 1'b0;
        endcase
    end

endmodule

/* src/sector_sorted_look_scheduler_unit.sv */
// Elevator-style disk request scheduler over a sector-sorted queue of up to QUEUE_DEPTH
// pending requests. Each request transfer produces exactly one result transfer. The entries
// live in a memory with one registered read port and one write port, and a small sequencer
// visits them one per cycle through one shared compare unit, so the time per request grows
// with the queue occupancy N. An add scans to the insertion point, shifts the tail up by one
// and writes the new entry; into an empty queue it only writes the entry. A dispatch while
// sweeping up, or a remove, scans to the entry and shifts the tail down; a dispatch while
// sweeping down scans from the top and then shifts every entry above the chosen one down.
// A neighbor query or a remove of a tag that is not present only scans; an add to a full
// queue, or any other request on an empty queue, goes straight to its result. The result
// becomes valid in the cycle the block is ready again. The block takes no new request while
// an operation is in progress; a finished result sits in an output register, so a new
// request can be accepted while the previous result still waits to be taken. No clearing
// pass is needed after reset.
module sector_sorted_look_scheduler_unit
    import sslsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          going_down_reg, going_down_next;
    sect_addr_t    last_sector_reg, last_sector_next;
    logic          pend_reg, pend_next;
    logic          m_valid_reg, m_valid_next;

    req_t          req_reg, req_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] left_reg, left_next;
    logic          step_down_reg, step_down_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    tag_t          prev_tag_reg, prev_tag_next;
    rsp_t          res_reg, res_next;
    rsp_t          m_data_reg, m_data_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    cmp_mode_t     cmp_mode;
    sect_addr_t    cmp_sector;
    logic          hit;
    logic          scan_last;
    logic          scan_stop;
    logic          out_free;
    logic [AW-1:0] sel_pos;

    sslsu_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Pick the test the shared compare unit applies to the entry just read.
    always_comb begin
        case (req_reg.req_type)
            REQ_ADD: begin
                cmp_mode   = CMP_NOT_BELOW;
                cmp_sector = req_reg.req_sector;
            end
            REQ_DISPATCH: begin
                cmp_mode   = going_down_reg ? CMP_BELOW : CMP_ABOVE;
                cmp_sector = last_sector_reg;
            end
            default: begin
                cmp_mode   = CMP_TAG_EQ;
                cmp_sector = last_sector_reg;
            end
        endcase
    end

    sslsu_cmp u_cmp (
        .mode       (cmp_mode),
        .entry      (rd_data),
        .key_sector (cmp_sector),
        .key_tag    (req_reg.req_tag),
        .hit        (hit)
    );

    // The scan ends on a match or after the last entry has been checked.
    assign scan_last = pend_reg && (left_reg == '0);
    assign scan_stop = pend_reg && (hit || scan_last);
    assign out_free  = !m_valid_reg || m_ready;

    // Chosen position: the match, or the insertion point past the end for an add,
    // or the last entry visited for a dispatch that has to turn around.
    always_comb begin
        if (hit) begin
            sel_pos = pend_idx_reg;
        end else if (req_reg.req_type == REQ_ADD) begin
            sel_pos = count_reg[AW-1:0];
        end else begin
            sel_pos = pend_idx_reg;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_data.req_type)
                        REQ_ADD: begin
                            if (count_reg == CW'(QUEUE_DEPTH)) begin
                                state_next = S_DONE;
                            end else if (count_reg == '0) begin
                                state_next = S_WRITE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_stop) begin
                    case (req_reg.req_type)
                        REQ_ADD, REQ_DISPATCH: begin
                            state_next = S_SHIFT;
                        end
                        REQ_REMOVE: begin
                            state_next = hit ? S_SHIFT : S_DONE;
                        end
                        default: begin
                            state_next = (hit && left_reg != '0) ? S_NEIGH : S_DONE;
                        end
                    endcase
                end
            end
            S_NEIGH: begin
                state_next = S_DONE;
            end
            S_SHIFT: begin
                if (left_reg == '0 && !pend_reg) begin
                    state_next = (req_reg.req_type == REQ_ADD) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control of the sequencer.
    always_comb begin
        count_next       = count_reg;
        going_down_next  = going_down_reg;
        last_sector_next = last_sector_reg;
        pend_next        = 1'b0;
        req_next         = req_reg;
        pos_next         = pos_reg;
        addr_next        = addr_reg;
        left_next        = left_reg;
        step_down_next   = step_down_reg;
        pend_idx_next    = pend_idx_reg;
        prev_tag_next    = prev_tag_reg;
        res_next         = res_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        rd_en            = 1'b0;
        rd_addr          = addr_reg;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data          = rd_data;
        s_ready          = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                // Latch the request and set up the scan.
                if (s_valid) begin
                    req_next        = s_data;
                    res_next        = '0;
                    res_next.status = STAT_OK;
                    prev_tag_next   = '0;
                    pos_next        = '0;
                    left_next       = count_reg;
                    if (s_data.req_type == REQ_DISPATCH && going_down_reg) begin
                        addr_next      = AW'(count_reg - CW'(1));
                        step_down_next = 1'b1;
                    end else begin
                        addr_next      = '0;
                        step_down_next = 1'b0;
                    end
                    case (s_data.req_type)
                        REQ_ADD: begin
                            if (count_reg == CW'(QUEUE_DEPTH)) begin
                                res_next.status = STAT_FULL;
                            end
                        end
                        REQ_DISPATCH: begin
                            if (count_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                res_next.status = STAT_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read one entry per cycle while the previous one is checked.
                if (left_reg != '0) begin
                    rd_en     = 1'b1;
                    addr_next = step_down_reg ? addr_reg - AW'(1) : addr_reg + AW'(1);
                    left_next = left_reg - CW'(1);
                end
                pend_next     = (left_reg != '0) && !scan_stop;
                pend_idx_next = addr_reg;
                if (pend_reg) begin
                    prev_tag_next = rd_data.tag;
                end
                if (scan_stop) begin
                    pos_next = sel_pos;
                    case (req_reg.req_type)
                        REQ_ADD: begin
                            // Move entries from the tail down to the insertion point up by one.
                            addr_next      = AW'(count_reg - CW'(1));
                            left_next      = count_reg - CW'(sel_pos);
                            step_down_next = 1'b1;
                        end
                        REQ_DISPATCH: begin
                            last_sector_next       = rd_data.sector;
                            res_next.served_tag    = rd_data.tag;
                            res_next.served_sector = rd_data.sector;
                            if (!hit) begin
                                going_down_next = !going_down_reg;
                            end
                            addr_next      = sel_pos + AW'(1);
                            left_next      = count_reg - CW'(1) - CW'(sel_pos);
                            step_down_next = 1'b0;
                            count_next     = count_reg - CW'(1);
                        end
                        REQ_REMOVE: begin
                            if (hit) begin
                                addr_next      = sel_pos + AW'(1);
                                left_next      = count_reg - CW'(1) - CW'(sel_pos);
                                step_down_next = 1'b0;
                                count_next     = count_reg - CW'(1);
                            end else begin
                                res_next.status = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            // The read of the following entry is already under way.
                            if (hit) begin
                                res_next.former_valid = (sel_pos != '0);
                                res_next.former_tag   = (sel_pos != '0) ? prev_tag_reg : '0;
                            end else begin
                                res_next.status = STAT_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            S_NEIGH: begin
                res_next.latter_valid = 1'b1;
                res_next.latter_tag   = rd_data.tag;
            end
            S_SHIFT: begin
                // Read one entry and write the previously read one to its new place.
                if (left_reg != '0) begin
                    rd_en         = 1'b1;
                    addr_next     = step_down_reg ? addr_reg - AW'(1) : addr_reg + AW'(1);
                    left_next     = left_reg - CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg;
                end
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = step_down_reg ? pend_idx_reg + AW'(1) : pend_idx_reg - AW'(1);
                    wr_data = rd_data;
                end
            end
            S_WRITE: begin
                wr_en          = 1'b1;
                wr_addr        = pos_reg;
                wr_data.tag    = req_reg.req_tag;
                wr_data.sector = req_reg.req_sector;
                count_next     = count_reg + CW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            going_down_reg  <= 1'b0;
            last_sector_reg <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            going_down_reg  <= going_down_next;
            last_sector_reg <= last_sector_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        pos_reg       <= pos_next;
        addr_reg      <= addr_next;
        left_reg      <= left_next;
        step_down_reg <= step_down_next;
        pend_idx_reg  <= pend_idx_next;
        prev_tag_reg  <= prev_tag_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* dv/sslsu_result_checker.sv */
module sslsu_result_checker
    import sslsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  rsp_t m_data,
    output int   fail_count,
    output int   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the sorted request queue and the head position.
    sect_addr_t q_sector [QUEUE_DEPTH];
    tag_t       q_tag    [QUEUE_DEPTH];
    int         q_count;
    logic       heading_down;
    sect_addr_t last_sector;

    // Results still owed by the block, oldest first.
    rsp_t pending_results [$];

    // Close the gap left by an entry that leaves the queue.
    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < q_count; i++) begin
            q_sector[i] = q_sector[i + 1];
            q_tag[i]    = q_tag[i + 1];
        end
        q_count--;
    endfunction

    // Position of the lowest-ordered entry with this tag, or -1.
    function automatic int locate_tag(input tag_t t);
        for (int i = 0; i < q_count; i++) begin
            if (q_tag[i] == t) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one request to the shadow queue and return the result it should give.
    function automatic rsp_t predict_look_result(input req_t r);
        rsp_t res;
        int   pos;
        bit   found;
        res   = '0;
        pos   = 0;
        found = 1'b0;
        case (r.req_type)
            REQ_ADD: begin
                if (q_count >= QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // The new entry goes in front of any with an equal sector.
                    while (pos < q_count && q_sector[pos] < r.req_sector) begin
                        pos++;
                    end
                    for (int i = q_count; i > pos; i--) begin
                        q_sector[i] = q_sector[i - 1];
                        q_tag[i]    = q_tag[i - 1];
                    end
                    q_sector[pos] = r.req_sector;
                    q_tag[pos]    = r.req_tag;
                    q_count++;
                    res.status = STAT_OK;
                end
            end
            REQ_DISPATCH: begin
                if (q_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    if (!heading_down) begin
                        for (int i = 0; i < q_count && !found; i++) begin
                            if (q_sector[i] > last_sector) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                        // Nothing above: turn around and take the largest entry.
                        if (!found) begin
                            heading_down = 1'b1;
                            pos          = q_count - 1;
                        end
                    end else begin
                        for (int i = q_count - 1; i >= 0 && !found; i--) begin
                            if (q_sector[i] < last_sector) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                        // Nothing below: turn around and take the smallest entry.
                        if (!found) begin
                            heading_down = 1'b0;
                            pos          = 0;
                        end
                    end
                    last_sector       = q_sector[pos];
                    res.status        = STAT_OK;
                    res.served_tag    = q_tag[pos];
                    res.served_sector = q_sector[pos];
                    drop_entry(pos);
                end
            end
            REQ_REMOVE: begin
                pos = locate_tag(r.req_tag);
                if (pos < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    drop_entry(pos);
                    res.status = STAT_OK;
                end
            end
            default: begin
                pos = locate_tag(r.req_tag);
                if (pos < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    res.status = STAT_OK;
                    if (pos > 0) begin
                        res.former_valid = 1'b1;
                        res.former_tag   = q_tag[pos - 1];
                    end
                    if (pos + 1 < q_count) begin
                        res.latter_valid = 1'b1;
                        res.latter_tag   = q_tag[pos + 1];
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Compare finished results first, then record the request taken at the same edge.
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            q_count      = 0;
            heading_down = 1'b0;
            last_sector  = '0;
            pending_results.delete();
            fail_count   = 0;
            outstanding  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no request waiting for it");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.served_tag !== want.served_tag) begin
                        $error("served_tag: expected %0d, got %0d",
                               want.served_tag, m_data.served_tag);
                        fail_count++;
                    end
                    if (m_data.served_sector !== want.served_sector) begin
                        $error("served_sector: expected %0h, got %0h",
                               want.served_sector, m_data.served_sector);
                        fail_count++;
                    end
                    if (m_data.former_valid !== want.former_valid) begin
                        $error("former_valid: expected %0d, got %0d",
                               want.former_valid, m_data.former_valid);
                        fail_count++;
                    end
                    if (m_data.former_tag !== want.former_tag) begin
                        $error("former_tag: expected %0d, got %0d",
                               want.former_tag, m_data.former_tag);
                        fail_count++;
                    end
                    if (m_data.latter_valid !== want.latter_valid) begin
                        $error("latter_valid: expected %0d, got %0d",
                               want.latter_valid, m_data.latter_valid);
                        fail_count++;
                    end
                    if (m_data.latter_tag !== want.latter_tag) begin
                        $error("latter_tag: expected %0d, got %0d",
                               want.latter_tag, m_data.latter_tag);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_look_result(s_data));
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* dv/sector_sorted_look_scheduler_unit_test.sv */
module sector_sorted_look_scheduler_unit_test
    import sslsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam sect_addr_t SECTOR_MAX = '1;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    int fail_count;
    int outstanding;
    int items_sent;
    bit burst_mode;

    sector_sorted_look_scheduler_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sslsu_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 aclk = ~aclk;

    function automatic req_t make_req(input req_type_t kind, input tag_t t, input sect_addr_t s);
        req_t r;
        r.req_type   = kind;
        r.req_tag    = t;
        r.req_sector = s;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none at all in burst stretches.
    function automatic int pick_gap(input bit no_idle);
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Random request; the mix leans toward adds while filling and dispatches while draining.
    function automatic req_t random_req(input int mix);
        req_type_t  kind;
        tag_t       t;
        sect_addr_t s;
        int         roll;
        int         add_pct;
        int         disp_pct;
        add_pct  = (mix == 0) ? 60 : (mix == 1) ? 20 : 35;
        disp_pct = (mix == 0) ? 15 : (mix == 1) ? 50 : 35;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            kind = REQ_ADD;
        end else if (roll < add_pct + disp_pct) begin
            kind = REQ_DISPATCH;
        end else if (roll < add_pct + disp_pct + (100 - add_pct - disp_pct) / 2) begin
            kind = REQ_REMOVE;
        end else begin
            kind = REQ_QUERY;
        end
        // A narrow tag range makes hits and duplicate tags common.
        t = ($urandom_range(0, 99) < 80) ? tag_t'($urandom_range(0, 15))
                                        : tag_t'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            s = sect_addr_t'($urandom_range(0, 63));
        end else if (roll < 85) begin
            s = sect_addr_t'({$urandom, $urandom});
        end else if (roll < 93) begin
            s = SECTOR_MAX;
        end else begin
            s = '0;
        end
        return make_req(kind, t, s);
    endfunction

    // Offer one request and hold it until the transfer happens; returns at a falling edge.
    task automatic send_req(input req_t r);
        int gap;
        gap = pick_gap(burst_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop offering until every owed result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin : result_side
        int  rx_wait;
        int  cycle_n;
        bit  rx_calm;
        bit  hold_done;
        rx_wait   = 0;
        cycle_n   = 0;
        rx_calm   = 1'b0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            cycle_n++;
            if (cycle_n % 600 == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            if (!hold_done && items_sent >= 300) begin
                hold_done = 1'b1;
                rx_wait   = 400;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!rx_calm) begin
                    rx_wait = pick_gap(1'b0);
                end
            end
        end
    end

    // Request side: reset, directed sequence, then random phases.
    initial begin : request_side
        req_t directed [$];
        int   mix;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_data     <= '0;
        items_sent  = 0;
        burst_mode  = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty queue: every lookup misses and dispatch reports empty.
        directed.push_back(make_req(REQ_REMOVE,   8'd5,   '0));
        directed.push_back(make_req(REQ_QUERY,    8'd5,   '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        // Extreme tags and sectors, an equal sector and a duplicate tag.
        directed.push_back(make_req(REQ_ADD,      8'd0,   SECTOR_MAX));
        directed.push_back(make_req(REQ_ADD,      8'd255, '0));
        directed.push_back(make_req(REQ_ADD,      8'd10,  sect_addr_t'(100)));
        directed.push_back(make_req(REQ_ADD,      8'd11,  sect_addr_t'(100)));
        directed.push_back(make_req(REQ_ADD,      8'd10,  sect_addr_t'(50)));
        // Neighbors in the middle, at the front and at the back; misses.
        directed.push_back(make_req(REQ_QUERY,    8'd10,  '0));
        directed.push_back(make_req(REQ_QUERY,    8'd255, '0));
        directed.push_back(make_req(REQ_QUERY,    8'd0,   '0));
        directed.push_back(make_req(REQ_QUERY,    8'd77,  '0));
        directed.push_back(make_req(REQ_REMOVE,   8'd77,  '0));
        // Sweep up, past the top, then turn around.
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        // Sweep down with the direction kept, then turn at the bottom.
        directed.push_back(make_req(REQ_ADD,      8'd200, sect_addr_t'(60)));
        directed.push_back(make_req(REQ_ADD,      8'd201, sect_addr_t'(100)));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        directed.push_back(make_req(REQ_REMOVE,   8'd201, '0));
        directed.push_back(make_req(REQ_DISPATCH, 8'd0,   '0));
        foreach (directed[i]) begin
            send_req(directed[i]);
        end

        // Random phases of 100 requests with changing mix and idling.
        for (int phase = 0; phase < 15; phase++) begin
            mix        = phase % 3;
            burst_mode = ($urandom_range(0, 3) == 0);
            if (phase == 7 || phase == 12) begin
                drain_results();
            end
            for (int k = 0; k < 100; k++) begin
                send_req(random_req(mix));
            end
        end

        // Let every owed result arrive, then allow the tail of the last operation.
        drain_results();
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Guard against a hang anywhere in the run.
    initial begin : watchdog
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
src/sslsu_pkg.sv
src/sslsu_mem.sv
src/sslsu_cmp.sv
src/sector_sorted_look_scheduler_unit.sv
dv/sslsu_result_checker.sv
dv/sector_sorted_look_scheduler_unit_test.sv
